FILE: hdl/swt_pkg.sv
package swt_pkg;

    // Sizing of the tokenizer.
    localparam int ARGS_MAX    = 64;
    localparam int ARG_BUF_MAX = 4096;

    localparam int COUNT_W = 7;   // argument count, limit and index
    localparam int LEN_W   = 12;  // bytes in the current argument
    localparam int SIZE_W  = 13;  // buffer size register
    localparam int STAT_W  = 3;
    localparam int CIDX_W  = 2;   // configuration register index

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_MANY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG    = 3'd2;
    localparam logic [STAT_W-1:0] ST_OPEN_SINGLE = 3'd3;
    localparam logic [STAT_W-1:0] ST_OPEN_DOUBLE = 3'd4;
    localparam logic [STAT_W-1:0] ST_TRAIL_BSL   = 3'd5;

    // Input commands.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_ARG_COUNT_LIMIT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ARG_BUFFER_SIZE = 2'd1;

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // Values the registers take at reset, already clamped.
    localparam logic [COUNT_W-1:0] LIMIT_RESET   = COUNT_W'(ARGS_MAX);
    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = LEN_W'(ARG_BUF_MAX - 1);

    // Parser state carried from one word to the next.
    typedef struct packed {
        logic                 in_single;
        logic                 in_double;
        logic                 escape_pending;
        logic                 arg_started;
        logic [LEN_W-1:0]     arg_length;
        logic [COUNT_W-1:0]   args_done;
        logic [STAT_W-1:0]    error_code;
    } t_parse_state;

    // One result word.
    typedef struct packed {
        logic                 has_byte;
        logic [7:0]           out_byte;
        logic [COUNT_W-1:0]   arg_index;
        logic                 ends_arg;
        logic                 done_res;
        logic [STAT_W-1:0]    status;
        logic [COUNT_W-1:0]   arg_count;
    } t_result;

    // Effective limits derived from the configuration registers.
    typedef struct packed {
        logic [COUNT_W-1:0]   limit;
        logic [LEN_W-1:0]     max_len;
    } t_limits;

endpackage

FILE: hdl/shell_word_tokenizer_core.sv
// Shell word tokenizer: one command byte or end marker per input word.
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the parser state and the output register
// are updated in the same cycle, so input is stalled only while a held result is stalled.
// Reset (synchronous, active low) clears the parser and sets the limits to 64 arguments and 4095 bytes.
module shell_word_tokenizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [7:0]                        i_char_byte,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_has_byte,
    output logic [7:0]                        o_out_byte,
    output logic [swt_pkg::COUNT_W-1:0]       o_arg_index,
    output logic                              o_ends_arg,
    output logic                              o_done_res,
    output logic [swt_pkg::STAT_W-1:0]        o_status,
    output logic [swt_pkg::COUNT_W-1:0]       o_arg_count,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swt_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [swt_pkg::SIZE_W-1:0]        i_cfg_data
);

    swt_pkg::t_limits      limits;
    swt_pkg::t_parse_state r_state;
    swt_pkg::t_parse_state n_state;
    swt_pkg::t_result      r_result;
    swt_pkg::t_result      n_result;
    logic                  r_out_valid;
    logic                  in_accept;

    // Configuration registers are always ready.
    assign o_cfg_ready = 1'b1;

    swt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    swt_step u_step (
        .i_state     (r_state),
        .i_limits    (limits),
        .i_cmd       (i_cmd),
        .i_char_byte (i_char_byte),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // A new word is taken unless the held result is still stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Parser state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_has_byte  = r_result.has_byte;
    assign o_out_byte  = r_result.out_byte;
    assign o_arg_index = r_result.arg_index;
    assign o_ends_arg  = r_result.ends_arg;
    assign o_done_res  = r_result.done_res;
    assign o_status    = r_result.status;
    assign o_arg_count = r_result.arg_count;

    // A word carries a byte, an argument end or neither, never both.
    a_byte_or_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(o_has_byte && o_ends_arg))
        else $error("byte and argument end in one result");

    // Bytes are only emitted while no error is held.
    a_byte_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_has_byte) |-> (o_status == swt_pkg::ST_OK))
        else $error("byte emitted with an error status");

    // The end marker leaves a clean parser behind.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_cmd == swt_pkg::CMD_END) |=>
            (r_state.args_done == '0 && r_state.error_code == swt_pkg::ST_OK &&
             !r_state.in_single && !r_state.in_double && !r_state.arg_started))
        else $error("parser state not cleared after end marker");

    // Accepting a word always produces a result word in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted word produced no result");

    // An argument end never comes with a status other than ok.
    a_end_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_ends_arg) |-> (o_status == swt_pkg::ST_OK && o_arg_count != '0))
        else $error("argument end with error or zero count");

endmodule

FILE: hdl/swt_cfg.sv
module swt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [swt_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [swt_pkg::SIZE_W-1:0]    i_cfg_data,
    output swt_pkg::t_limits              o_limits
);

    swt_pkg::t_limits r_limits;
    swt_pkg::t_limits n_limits;

    logic [swt_pkg::COUNT_W-1:0] limit_raw;
    logic [swt_pkg::SIZE_W-1:0]  size_clamped;
    logic [swt_pkg::SIZE_W-1:0]  size_less_one;

    // Clamp the written values once, so the parser only sees the usable limits.
    always_comb begin
        limit_raw     = i_cfg_data[swt_pkg::COUNT_W-1:0];
        size_clamped  = (i_cfg_data > swt_pkg::SIZE_W'(swt_pkg::ARG_BUF_MAX))
                      ? swt_pkg::SIZE_W'(swt_pkg::ARG_BUF_MAX) : i_cfg_data;
        size_less_one = (size_clamped == '0) ? '0 : size_clamped - 1'b1;
        n_limits      = r_limits;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swt_pkg::CFG_ARG_COUNT_LIMIT: begin
                    n_limits.limit = (limit_raw > swt_pkg::COUNT_W'(swt_pkg::ARGS_MAX))
                                   ? swt_pkg::COUNT_W'(swt_pkg::ARGS_MAX) : limit_raw;
                end
                swt_pkg::CFG_ARG_BUFFER_SIZE: begin
                    n_limits.max_len = size_less_one[swt_pkg::LEN_W-1:0];
                end
                default: begin
                    n_limits = r_limits;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.limit   <= swt_pkg::LIMIT_RESET;
            r_limits.max_len <= swt_pkg::MAX_LEN_RESET;
        end else begin
            r_limits <= n_limits;
        end
    end

    assign o_limits = r_limits;

endmodule

FILE: hdl/swt_step.sv
module swt_step (
    input  swt_pkg::t_parse_state   i_state,
    input  swt_pkg::t_limits        i_limits,
    input  logic                    i_cmd,
    input  logic [7:0]              i_char_byte,
    output swt_pkg::t_parse_state   o_state,
    output swt_pkg::t_result        o_result
);

    swt_pkg::t_parse_state st;
    logic                  has_byte;
    logic                  ends;
    logic                  done;
    logic                  is_blank;
    logic                  len_full;
    logic                  count_full;

    // Decide one word: the next parser state and the result it produces.
    always_comb begin
        st         = i_state;
        has_byte   = 1'b0;
        ends       = 1'b0;
        done       = 1'b0;
        is_blank   = (i_char_byte == swt_pkg::CH_SPACE) || (i_char_byte == swt_pkg::CH_TAB);
        len_full   = (i_state.arg_length >= i_limits.max_len);
        count_full = (i_state.args_done >= i_limits.limit);

        if (i_cmd == swt_pkg::CMD_BYTE) begin
            priority if (i_state.error_code != swt_pkg::ST_OK) begin
                // Locked after an error until the end marker.
                st = i_state;
            end else if (i_state.escape_pending ||
                         !((i_char_byte == swt_pkg::CH_BSLASH && !i_state.in_single) ||
                           (i_char_byte == swt_pkg::CH_SQUOTE && !i_state.in_double) ||
                           (i_char_byte == swt_pkg::CH_DQUOTE && !i_state.in_single) ||
                           (is_blank && !i_state.in_single && !i_state.in_double))) begin
                // Literal byte: escaped or plain.
                st.escape_pending = 1'b0;
                if (len_full) begin
                    st.error_code = swt_pkg::ST_TOO_LONG;
                end else begin
                    st.arg_length  = i_state.arg_length + 1'b1;
                    st.arg_started = 1'b1;
                    has_byte       = 1'b1;
                end
            end else if (i_char_byte == swt_pkg::CH_BSLASH && !i_state.in_single) begin
                st.escape_pending = 1'b1;
                st.arg_started    = 1'b1;
            end else if (i_char_byte == swt_pkg::CH_SQUOTE && !i_state.in_double) begin
                st.in_single   = !i_state.in_single;
                st.arg_started = 1'b1;
            end else if (i_char_byte == swt_pkg::CH_DQUOTE && !i_state.in_single) begin
                st.in_double   = !i_state.in_double;
                st.arg_started = 1'b1;
            end else begin
                // Unquoted blank: closes an argument that has been started.
                if (i_state.arg_started) begin
                    if (count_full) begin
                        st.error_code = swt_pkg::ST_TOO_MANY;
                    end else begin
                        st.args_done   = i_state.args_done + 1'b1;
                        st.arg_length  = '0;
                        st.arg_started = 1'b0;
                        ends           = 1'b1;
                    end
                end
            end
        end else begin
            // End marker: check open constructs, then close the last argument.
            done = 1'b1;
            if (i_state.error_code == swt_pkg::ST_OK) begin
                priority if (i_state.in_single) begin
                    st.error_code = swt_pkg::ST_OPEN_SINGLE;
                end else if (i_state.in_double) begin
                    st.error_code = swt_pkg::ST_OPEN_DOUBLE;
                end else if (i_state.escape_pending) begin
                    st.error_code = swt_pkg::ST_TRAIL_BSL;
                end else if (i_state.arg_started) begin
                    if (count_full) begin
                        st.error_code = swt_pkg::ST_TOO_MANY;
                    end else begin
                        st.args_done   = i_state.args_done + 1'b1;
                        st.arg_length  = '0;
                        st.arg_started = 1'b0;
                        ends           = 1'b1;
                    end
                end else begin
                    st = i_state;
                end
            end
        end

        o_result.has_byte  = has_byte;
        o_result.out_byte  = has_byte ? i_char_byte : 8'h00;
        o_result.arg_index = i_state.args_done;
        o_result.ends_arg  = ends;
        o_result.done_res  = done;
        o_result.status    = st.error_code;
        o_result.arg_count = st.args_done;

        // The end marker leaves a clean parser for the next string.
        if (done) begin
            o_state = '0;
        end else begin
            o_state = st;
        end
    end

endmodule
